[rtl/nirf_pkg.sv]
// Shared types and constants for the NEC IR frame decoder.
package nirf_pkg;

	localparam int RUN_BITS_DEF = 16;
	localparam int LEN_W        = 10;
	localparam int TOL_W        = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 10;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [LEN_W-1:0] LEADER_MARK_RST  = LEN_W'(342);
	localparam logic [LEN_W-1:0] LEADER_SPACE_RST = LEN_W'(171);
	localparam logic [LEN_W-1:0] BIT_MARK_RST     = LEN_W'(21);
	localparam logic [LEN_W-1:0] ZERO_SPACE_RST   = LEN_W'(21);
	localparam logic [LEN_W-1:0] ONE_SPACE_RST    = LEN_W'(64);
	localparam logic [TOL_W-1:0] TOLERANCE_RST    = TOL_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEADER_MARK  = 3'd0,
		CFG_LEADER_SPACE = 3'd1,
		CFG_BIT_MARK     = 3'd2,
		CFG_ZERO_SPACE   = 3'd3,
		CFG_ONE_SPACE    = 3'd4,
		CFG_TOLERANCE    = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_LEADER_MARK = 3'd1,
		ST_LEADER_SPC  = 3'd2,
		ST_BIT_MARK    = 3'd3,
		ST_BIT_SPACE   = 3'd4,
		ST_CHECK       = 3'd5,
		ST_TRUNC       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_LEADER_MARK  = 2'd0,
		PH_LEADER_SPACE = 2'd1,
		PH_BIT_MARK     = 2'd2,
		PH_BIT_SPACE    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0] leader_mark_len;
		logic [LEN_W-1:0] leader_space_len;
		logic [LEN_W-1:0] bit_mark_len;
		logic [LEN_W-1:0] zero_space_len;
		logic [LEN_W-1:0] one_space_len;
		logic [TOL_W-1:0] tolerance;
	} cfg_t;

	// Classification of one run, independent of the decoder phase.
	typedef struct packed {
		logic lead_mark_ok;
		logic lead_space_ok;
		logic bit_mark_ok;
		logic zero_ok;
		logic one_ok;
		logic last;
	} run_class_t;

endpackage

[rtl/nirf_front.sv]
// Front end: compares each run against all length windows.
module nirf_front #(
	parameter int RUN_BITS = nirf_pkg::RUN_BITS_DEF
) (
	input  nirf_pkg::cfg_t       cfg,
	input  logic                 level,
	input  logic [RUN_BITS-1:0]  run_length,
	input  logic                 last_run,
	output nirf_pkg::run_class_t cls
);
	import nirf_pkg::*;

	localparam int EW = RUN_BITS + 1;

	logic [EW-1:0] run_ext;
	logic [EW-1:0] run_plus_tol;

	function automatic logic in_closed(input logic [EW-1:0] rpt, input logic [EW-1:0] run,
		input logic [LEN_W-1:0] nom, input logic [TOL_W-1:0] tol);
		logic [LEN_W:0] hi;
		hi = (LEN_W+1)'(nom) + (LEN_W+1)'(tol);
		return (rpt >= EW'(nom)) && (run <= EW'(hi));
	endfunction

	function automatic logic in_open(input logic [EW-1:0] rpt, input logic [EW-1:0] run,
		input logic [LEN_W-1:0] nom, input logic [TOL_W-1:0] tol);
		logic [LEN_W:0] hi;
		hi = (LEN_W+1)'(nom) + (LEN_W+1)'(tol);
		return (rpt > EW'(nom)) && (run < EW'(hi));
	endfunction

	assign run_ext      = EW'(run_length);
	assign run_plus_tol = run_ext + EW'(cfg.tolerance);

	always_comb begin
		cls.lead_mark_ok  = !level && in_closed(run_plus_tol, run_ext,
			cfg.leader_mark_len, cfg.tolerance);
		cls.lead_space_ok = level && in_closed(run_plus_tol, run_ext,
			cfg.leader_space_len, cfg.tolerance);
		cls.bit_mark_ok   = !level && in_closed(run_plus_tol, run_ext,
			cfg.bit_mark_len, cfg.tolerance);
		cls.zero_ok       = level && in_open(run_plus_tol, run_ext,
			cfg.zero_space_len, cfg.tolerance);
		cls.one_ok        = level && in_open(run_plus_tol, run_ext,
			cfg.one_space_len, cfg.tolerance);
		cls.last          = last_run;
	end

endmodule

[rtl/nirf_queue.sv]
// Short queue of classified runs between front and back.
module nirf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nirf_pkg::run_class_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output nirf_pkg::run_class_t pop_data
);
	import nirf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	run_class_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/nirf_back.sv]
// Back end: frame state machine, bit assembly and result register.
module nirf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cls_valid,
	input  nirf_pkg::run_class_t cls,
	output logic                 cls_take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [7:0]           address,
	output logic [7:0]           addr_high,
	output logic [7:0]           command
);
	import nirf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [4:0]  bit_count_q, bit_count_d;
	logic [31:0] shift_q, shift_d;

	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  address_q, addr_high_q, command_q;

	logic        step;
	logic        bit_val;
	logic [31:0] shift_new;
	logic        emit;
	status_t     emit_status;
	logic [23:0] emit_data;

	assign cls_take  = cls_valid && (!out_valid_q || out_ready);
	assign step      = cls_take;
	assign bit_val   = !cls.zero_ok;
	assign shift_new = {bit_val, shift_q[31:1]};

	// Next state
	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		if (step) begin
			unique case (phase_q)
				PH_LEADER_MARK: begin
					if (cls.lead_mark_ok) phase_d = PH_LEADER_SPACE;
				end
				PH_LEADER_SPACE: begin
					if (cls.lead_space_ok) begin
						phase_d     = PH_BIT_MARK;
						bit_count_d = '0;
						shift_d     = '0;
					end else begin
						phase_d = PH_LEADER_MARK;
					end
				end
				PH_BIT_MARK: begin
					phase_d = cls.bit_mark_ok ? PH_BIT_SPACE : PH_LEADER_MARK;
				end
				PH_BIT_SPACE: begin
					if ((cls.zero_ok || cls.one_ok) && bit_count_q != 5'd31) begin
						phase_d     = PH_BIT_MARK;
						bit_count_d = bit_count_q + 1'b1;
						shift_d     = shift_new;
					end else begin
						phase_d = PH_LEADER_MARK;
					end
				end
				default: phase_d = PH_LEADER_MARK;
			endcase
			// truncation of a still-open frame
			if (cls.last && phase_d != PH_LEADER_MARK) phase_d = PH_LEADER_MARK;
			if (phase_d == PH_LEADER_MARK || phase_d == PH_LEADER_SPACE) begin
				bit_count_d = '0;
				shift_d     = '0;
			end
		end
	end

	// Outputs
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_data   = '0;
		unique case (phase_q)
			PH_LEADER_MARK: begin
				emit        = !cls.lead_mark_ok || cls.last;
				emit_status = !cls.lead_mark_ok ? ST_LEADER_MARK : ST_TRUNC;
			end
			PH_LEADER_SPACE: begin
				emit        = !cls.lead_space_ok || cls.last;
				emit_status = !cls.lead_space_ok ? ST_LEADER_SPC : ST_TRUNC;
			end
			PH_BIT_MARK: begin
				emit        = !cls.bit_mark_ok || cls.last;
				emit_status = !cls.bit_mark_ok ? ST_BIT_MARK : ST_TRUNC;
			end
			PH_BIT_SPACE: begin
				if (!(cls.zero_ok || cls.one_ok)) begin
					emit        = 1'b1;
					emit_status = ST_BIT_SPACE;
				end else if (bit_count_q == 5'd31) begin
					emit = 1'b1;
					if ((shift_new[23:16] ^ shift_new[31:24]) != 8'hFF) begin
						emit_status = ST_CHECK;
					end else begin
						emit_status = ST_OK;
						emit_data   = shift_new[23:0];
					end
				end else begin
					emit        = cls.last;
					emit_status = ST_TRUNC;
				end
			end
			default: begin
				emit        = 1'b0;
				emit_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEADER_MARK;
			bit_count_q <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			shift_q     <= shift_d;
			if (step) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_q    <= emit_status;
			address_q   <= emit_data[7:0];
			addr_high_q <= emit_data[15:8];
			command_q   <= emit_data[23:16];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign address   = address_q;
	assign addr_high = addr_high_q;
	assign command   = command_q;

	a_err_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |->
		(address_q == 8'h00 && addr_high_q == 8'h00 && command_q == 8'h00))
		else $error("error result carries nonzero payload");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEADER_MARK || phase_q == PH_LEADER_SPACE) |->
		(bit_count_q == 5'd0 && shift_q == 32'd0))
		else $error("frame state not cleared outside data phase");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cls.last) |=> (phase_q == PH_LEADER_MARK))
		else $error("last run left a frame open");

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cls.last) |=> out_valid_q)
		else $error("last run produced no result");

endmodule

[rtl/nec_ir_frame_decoder_top.sv]
// Top level of the NEC IR frame decoder: config registers, front, queue, back.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, level, run_length, last_run | sink
//  out     | out_valid/out_ready, status, address,          | source
//          | addr_high, command                             |
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | sink
//
// One run per cycle while the queue has room. The window compare is combinational into
// the queue register; the state machine step that pops a run loads out_valid and the result.
// The four-entry queue absorbs output stalls; in_ready drops only when it is full.
// cfg_ready is always high. Reset loads the nominal NEC timing and waits for a leader mark.
module nec_ir_frame_decoder_top #(
	parameter int RUN_BITS = nirf_pkg::RUN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            level,
	input  logic [RUN_BITS-1:0]             run_length,
	input  logic                            last_run,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      status,
	output logic [7:0]                      address,
	output logic [7:0]                      addr_high,
	output logic [7:0]                      command,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nirf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nirf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nirf_pkg::*;

	cfg_t       cfg_q;
	run_class_t front_cls;
	run_class_t back_cls;
	logic       queue_full;
	logic       queue_not_empty;
	logic       queue_pop;
	logic       in_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !queue_full;
	assign in_take   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_mark_len  <= LEADER_MARK_RST;
			cfg_q.leader_space_len <= LEADER_SPACE_RST;
			cfg_q.bit_mark_len     <= BIT_MARK_RST;
			cfg_q.zero_space_len   <= ZERO_SPACE_RST;
			cfg_q.one_space_len    <= ONE_SPACE_RST;
			cfg_q.tolerance        <= TOLERANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEADER_MARK:  cfg_q.leader_mark_len  <= cfg_data;
				CFG_LEADER_SPACE: cfg_q.leader_space_len <= cfg_data;
				CFG_BIT_MARK:     cfg_q.bit_mark_len     <= cfg_data;
				CFG_ZERO_SPACE:   cfg_q.zero_space_len   <= cfg_data;
				CFG_ONE_SPACE:    cfg_q.one_space_len    <= cfg_data;
				CFG_TOLERANCE:    cfg_q.tolerance        <= cfg_data[TOL_W-1:0];
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	nirf_front #(
		.RUN_BITS (RUN_BITS)
	) u_front (
		.cfg        (cfg_q),
		.level      (level),
		.run_length (run_length),
		.last_run   (last_run),
		.cls        (front_cls)
	);

	nirf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_take),
		.push_data (front_cls),
		.full      (queue_full),
		.pop       (queue_pop),
		.not_empty (queue_not_empty),
		.pop_data  (back_cls)
	);

	nirf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (queue_not_empty),
		.cls       (back_cls),
		.cls_take  (queue_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.address   (address),
		.addr_high (addr_high),
		.command   (command)
	);

endmodule
